// ===== sv/tss_pkg.sv =====
package tss_pkg;

    localparam int KEY_MAX = 32;
    localparam int KA_W    = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int KL_W    = $clog2(KEY_MAX + 1);

    localparam logic [7:0] CH_E    = 8'h65;
    localparam logic [7:0] CH_S    = 8'h73;
    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_EQ   = 8'h3D;

    localparam logic [2:0] K_KEY  = 3'd0;
    localparam logic [2:0] K_VAL  = 3'd1;
    localparam logic [2:0] K_PAIR = 3'd2;
    localparam logic [2:0] K_ERR  = 3'd3;
    localparam logic [2:0] K_END  = 3'd4;

    // Result slots of one input byte, in the order they are sent.
    localparam logic [2:0] SL_KEYS = 3'd0;
    localparam logic [2:0] SL_VA   = 3'd1;
    localparam logic [2:0] SL_VB   = 3'd2;
    localparam logic [2:0] SL_CL1  = 3'd3;
    localparam logic [2:0] SL_CL2  = 3'd4;
    localparam logic [2:0] SL_END  = 3'd5;
    localparam logic [2:0] SL_NONE = 3'd6;
    localparam int         NSLOT   = 6;

    typedef struct packed {
        logic       accept;
        logic       emit;
        logic [2:0] slot;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic [NSLOT-1:0] plan;
        logic             key_last;
        logic             out_free;
    } t_stat;

    function automatic logic is_special(input logic [7:0] c);
        return (c == CH_E) || (c == CH_S) || (c == CH_BSL);
    endfunction

    function automatic logic [7:0] unesc_map(input logic [7:0] c);
        logic [7:0] r;
        r = CH_BSL;
        if (c == CH_E) begin
            r = CH_EQ;
        end else if (c == CH_S) begin
            r = CH_SEMI;
        end
        return r;
    endfunction

    function automatic logic [2:0] first_from(input logic [NSLOT-1:0] plan,
                                              input logic [2:0] start);
        logic [2:0] r;
        logic       found;
        r = SL_NONE;
        found = 1'b0;
        for (int i = 0; i < NSLOT; i++) begin
            if (!found && (3'(i) >= start) && plan[i]) begin
                r = 3'(i);
                found = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

// ===== sv/tss_ram.sv =====
module tss_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 32
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [DATA_W-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [DATA_W-1:0]                          o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/tss_ctrl.sv =====
module tss_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  tss_pkg::t_stat i_stat,
    output tss_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] ST_IDLE = tss_pkg::SL_NONE;
    localparam logic [2:0] ST_DISP = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [2:0] nxt_slot;
    logic       ready;

    assign ready = (r_state == ST_IDLE);
    assign o_s_tready = ready;
    assign nxt_slot = tss_pkg::first_from(i_stat.plan, r_state + 3'd1);

    always_comb begin
        n_state = r_state;
        o_cmd.accept = ready && i_s_tvalid;
        o_cmd.emit = 1'b0;
        o_cmd.slot = r_state;
        o_cmd.last = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_DISP;
                end
            end
            ST_DISP: begin
                n_state = tss_pkg::first_from(i_stat.plan, tss_pkg::SL_KEYS);
            end
            default: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if ((r_state == tss_pkg::SL_KEYS) && !i_stat.key_last) begin
                        n_state = r_state;
                    end else begin
                        n_state = nxt_slot;
                        o_cmd.last = (nxt_slot == tss_pkg::SL_NONE);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/tss_dp.sv =====
module tss_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_in_byte,
    input  logic          i_in_eos,
    input  tss_pkg::t_cmd  i_cmd,
    output tss_pkg::t_stat o_stat,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [2:0]    o_m_kind,
    output logic [7:0]    o_m_byte,
    output logic          o_m_last
);

    localparam logic [2:0] PH_KEY     = 3'd0;
    localparam logic [2:0] PH_VSTART  = 3'd1;
    localparam logic [2:0] PH_VALUE   = 3'd2;
    localparam logic [2:0] PH_SKIP    = 3'd3;
    localparam logic [2:0] PH_DISCARD = 3'd4;

    localparam int KA_W = tss_pkg::KA_W;
    localparam int KL_W = tss_pkg::KL_W;

    logic [2:0]      r_ph, n_ph;
    logic            r_esc, n_esc;
    logic [KL_W-1:0] r_klen, n_klen;
    logic            r_kovf, n_kovf;
    logic            r_kbad, n_kbad;

    logic [tss_pkg::NSLOT-1:0] r_plan, p_plan;
    logic [7:0]      r_va, p_va;
    logic [7:0]      r_vb, p_vb;
    logic            r_cl1_err, p_cl1_err;
    logic            r_cl2_err, p_cl2_err;
    logic [KL_W-1:0] r_kcnt;
    logic [KL_W-1:0] r_kidx, n_kidx;

    logic            r_ovalid;
    logic [2:0]      r_okind;
    logic [7:0]      r_obyte;
    logic            r_olast;

    logic            we;
    logic [KA_W-1:0] waddr;
    logic [7:0]      wdata;
    logic [7:0]      rdata;
    logic [7:0]      c;
    logic            klen_ok;
    logic            klen_ok2;
    logic            do_val;
    logic            do_clear;
    logic            esc_in;
    logic            out_free;
    logic [2:0]      e_kind;
    logic [7:0]      e_byte;

    assign c = i_in_byte;
    assign klen_ok = r_klen < KL_W'(tss_pkg::KEY_MAX);
    assign klen_ok2 = ({1'b0, r_klen} + (KL_W + 1)'(1)) < (KL_W + 1)'(tss_pkg::KEY_MAX);

    always_comb begin
        n_ph = r_ph;
        n_esc = r_esc;
        n_klen = r_klen;
        n_kovf = r_kovf;
        n_kbad = r_kbad;
        p_plan = '0;
        p_va = 8'h00;
        p_vb = 8'h00;
        p_cl1_err = 1'b0;
        p_cl2_err = 1'b0;
        we = 1'b0;
        waddr = r_klen[KA_W-1:0];
        wdata = c;
        do_val = 1'b0;
        do_clear = 1'b0;
        esc_in = 1'b0;
        case (r_ph)
            PH_KEY: begin
                if (c == tss_pkg::CH_SEMI) begin
                    do_clear = 1'b1;
                end else if (c == tss_pkg::CH_EQ) begin
                    n_kbad = r_esc;
                    n_esc = 1'b0;
                    n_ph = PH_VSTART;
                end else if (r_esc) begin
                    n_esc = 1'b0;
                    if (!klen_ok) begin
                        n_kovf = 1'b1;
                    end else if (tss_pkg::is_special(c)) begin
                        we = 1'b1;
                        wdata = tss_pkg::unesc_map(c);
                        n_klen = r_klen + KL_W'(1);
                    end else if (klen_ok2) begin
                        // The backslash already sits at the current length.
                        we = 1'b1;
                        waddr = KA_W'(r_klen + KL_W'(1));
                        n_klen = r_klen + KL_W'(2);
                    end else begin
                        n_klen = r_klen + KL_W'(1);
                        n_kovf = 1'b1;
                    end
                end else if (c == tss_pkg::CH_BSL) begin
                    n_esc = 1'b1;
                    we = klen_ok;
                end else if (klen_ok) begin
                    we = 1'b1;
                    n_klen = r_klen + KL_W'(1);
                end else begin
                    n_kovf = 1'b1;
                end
            end
            PH_VSTART: begin
                if (c == tss_pkg::CH_SEMI) begin
                    do_clear = 1'b1;
                end else if (c == tss_pkg::CH_EQ) begin
                    n_ph = PH_SKIP;
                end else if (r_kovf || r_kbad) begin
                    p_plan[tss_pkg::SL_CL1] = 1'b1;
                    p_cl1_err = 1'b1;
                    n_ph = PH_DISCARD;
                end else if (r_klen == '0) begin
                    n_ph = PH_SKIP;
                end else begin
                    p_plan[tss_pkg::SL_KEYS] = 1'b1;
                    n_ph = PH_VALUE;
                    do_val = 1'b1;
                end
            end
            PH_VALUE: begin
                if ((c == tss_pkg::CH_SEMI) || (c == tss_pkg::CH_EQ)) begin
                    p_plan[tss_pkg::SL_CL1] = 1'b1;
                    if (r_esc) begin
                        p_cl1_err = 1'b1;
                        n_esc = 1'b0;
                        n_ph = PH_DISCARD;
                    end else if (c == tss_pkg::CH_SEMI) begin
                        do_clear = 1'b1;
                    end else begin
                        n_ph = PH_SKIP;
                    end
                end else begin
                    do_val = 1'b1;
                    esc_in = r_esc;
                end
            end
            PH_SKIP: begin
                if (c == tss_pkg::CH_SEMI) begin
                    do_clear = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (do_val) begin
            n_esc = 1'b0;
            if (esc_in) begin
                p_plan[tss_pkg::SL_VA] = 1'b1;
                if (tss_pkg::is_special(c)) begin
                    p_va = tss_pkg::unesc_map(c);
                end else begin
                    p_va = tss_pkg::CH_BSL;
                    p_vb = c;
                    p_plan[tss_pkg::SL_VB] = 1'b1;
                end
            end else if (c == tss_pkg::CH_BSL) begin
                n_esc = 1'b1;
            end else begin
                p_plan[tss_pkg::SL_VA] = 1'b1;
                p_va = c;
            end
        end

        if (do_clear || i_in_eos) begin
            if (i_in_eos) begin
                p_plan[tss_pkg::SL_END] = 1'b1;
                if (!do_clear && (n_ph == PH_VALUE)) begin
                    p_plan[tss_pkg::SL_CL2] = 1'b1;
                    p_cl2_err = n_esc;
                end
            end
            n_ph = PH_KEY;
            n_esc = 1'b0;
            n_klen = '0;
            n_kovf = 1'b0;
            n_kbad = 1'b0;
        end
    end

    always_comb begin
        n_kidx = r_kidx;
        if (i_cmd.accept) begin
            n_kidx = '0;
        end else if (i_cmd.emit && (i_cmd.slot == tss_pkg::SL_KEYS)) begin
            n_kidx = r_kidx + KL_W'(1);
        end
    end

    tss_ram #(
        .DATA_W(8),
        .DEPTH (tss_pkg::KEY_MAX)
    ) u_key_ram (
        .i_clk  (i_clk),
        .i_we   (we && i_cmd.accept),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(n_kidx[KA_W-1:0]),
        .o_rdata(rdata)
    );

    always_comb begin
        e_kind = tss_pkg::K_END;
        e_byte = 8'h00;
        case (i_cmd.slot)
            tss_pkg::SL_KEYS: begin
                e_kind = tss_pkg::K_KEY;
                e_byte = rdata;
            end
            tss_pkg::SL_VA: begin
                e_kind = tss_pkg::K_VAL;
                e_byte = r_va;
            end
            tss_pkg::SL_VB: begin
                e_kind = tss_pkg::K_VAL;
                e_byte = r_vb;
            end
            tss_pkg::SL_CL1: begin
                e_kind = r_cl1_err ? tss_pkg::K_ERR : tss_pkg::K_PAIR;
            end
            tss_pkg::SL_CL2: begin
                e_kind = r_cl2_err ? tss_pkg::K_ERR : tss_pkg::K_PAIR;
            end
            default: begin
                e_kind = tss_pkg::K_END;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_KEY;
            r_esc <= 1'b0;
            r_klen <= '0;
            r_kovf <= 1'b0;
            r_kbad <= 1'b0;
            r_plan <= '0;
            r_kidx <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_ph <= n_ph;
                r_esc <= n_esc;
                r_klen <= n_klen;
                r_kovf <= n_kovf;
                r_kbad <= n_kbad;
                r_plan <= p_plan;
            end
            r_kidx <= n_kidx;
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_va <= p_va;
            r_vb <= p_vb;
            r_cl1_err <= p_cl1_err;
            r_cl2_err <= p_cl2_err;
            r_kcnt <= r_klen;
        end
        if (i_cmd.emit) begin
            r_okind <= e_kind;
            r_obyte <= e_byte;
            r_olast <= i_cmd.last;
        end
    end

    assign out_free = !r_ovalid || i_m_tready;

    assign o_stat.plan = r_plan;
    assign o_stat.key_last = ((r_kidx + KL_W'(1)) == r_kcnt);
    assign o_stat.out_free = out_free;

    assign o_m_tvalid = r_ovalid;
    assign o_m_kind = r_okind;
    assign o_m_byte = r_obyte;
    assign o_m_last = r_olast;

endmodule

// ===== sv/tag_string_splitter.sv =====
// Tag string splitter.
// The input stream carries one raw byte of a tag string per transfer in
// s_axis_tdata, with s_axis_tlast on the final byte of the string.
// The output stream carries one result per transfer: the kind in
// m_axis_tuser, the unescaped byte in m_axis_tdata (zero for pair end,
// error and string end), and m_axis_tlast on the last result of an input.
// One input byte is handled at a time. After a transfer in, a dispatch
// state follows, then one result leaves per cycle while the receiver keeps
// up. The first value byte of a pair flushes the buffered key, up to
// KEY_MAX bytes, from a key memory with separate read and write ports,
// one byte per cycle while the receiver keeps up.
// When the receiver stalls, the result stays in the output register and
// the block waits; input is taken again once the last result of the byte
// has entered the output register.
// Reset clears the parser state and the output valid flag; the key memory
// is not cleared, since only entries below the stored key length are read.
module tag_string_splitter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // [7:0] out_byte
    output logic [2:0] m_axis_tuser,  // [2:0] kind
    output logic       m_axis_tlast
);

    tss_pkg::t_cmd  cmd;
    tss_pkg::t_stat stat;

    tss_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_axis_tvalid),
        .o_s_tready(s_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    tss_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_byte (s_axis_tdata),
        .i_in_eos  (s_axis_tlast),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .o_m_tvalid(m_axis_tvalid),
        .i_m_tready(m_axis_tready),
        .o_m_kind  (m_axis_tuser),
        .o_m_byte  (m_axis_tdata),
        .o_m_last  (m_axis_tlast)
    );

endmodule

// ===== sv/tss_checker.sv =====
module tss_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [2:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    // A stalled result is not withdrawn.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // One byte at a time: no input right after a transfer in.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a byte is in work");

    // Only key and value results carry a byte.
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == tss_pkg::K_PAIR ||
            m_axis_tuser == tss_pkg::K_ERR || m_axis_tuser == tss_pkg::K_END)
        |-> m_axis_tdata == 8'h00)
        else $error("nonzero byte on a control result");

    // A string end is always the last result of its input.
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == tss_pkg::K_END) |-> m_axis_tlast)
        else $error("string end not marked last");

endmodule

bind tag_string_splitter tss_checker u_tss_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
);

// ===== dv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_BYTES = 400;
    localparam int HOLD_AFTER   = 120;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam int BY_MODEL     = -1;

    typedef enum logic [2:0] {
        SEG_KEY, SEG_VSTART, SEG_VALUE, SEG_SKIP, SEG_DISCARD
    } t_seg_phase;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       last;
    } t_split_result;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_tag_byte;

    typedef struct {
        logic [7:0] data;
        logic       last;
        int         n_exp;
        logic [2:0] k0;
        logic [2:0] k1;
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;  // [7:0] in_byte
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;          // [7:0] out_byte
    logic [2:0] m_axis_tuser;          // [2:0] kind
    logic       m_axis_tlast;

    int         drv_n_exp = BY_MODEL;
    logic [2:0] drv_k0 = tss_pkg::K_END;
    logic [2:0] drv_k1 = tss_pkg::K_END;

    t_seg_phase    seg_phase;
    logic          esc_pend;
    logic [7:0]    key_buf [tss_pkg::KEY_MAX];
    int            key_len;
    logic          key_ovf;
    logic          key_esc_err;
    t_split_result byte_results[$];
    t_split_result expected_results[$];
    t_split_result front;
    t_split_result exp_item;
    t_tag_byte     tag_bytes[$];

    int errors = 0;
    int bytes_in = 0;
    int results_seen = 0;
    int strings_seen = 0;
    int pairs_seen = 0;
    int errors_seen = 0;
    int longest_run = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    bit hold_done = 1'b0;

    t_dir_row dir_rows [27] = '{
        '{tss_pkg::CH_EQ,   1'b1, 1,        tss_pkg::K_END,  tss_pkg::K_END},
        '{"a",              1'b0, BY_MODEL, tss_pkg::K_END,  tss_pkg::K_END},
        '{tss_pkg::CH_EQ,   1'b0, BY_MODEL, tss_pkg::K_END,  tss_pkg::K_END},
        '{8'hFF,            1'b0, BY_MODEL, tss_pkg::K_END,  tss_pkg::K_END},
        '{8'h00,            1'b0, BY_MODEL, tss_pkg::K_END,  tss_pkg::K_END},
        '{tss_pkg::CH_SEMI, 1'b0, 1,        tss_pkg::K_PAIR, tss_pkg::K_END},
        '{tss_pkg::CH_BSL,  1'b0, BY_MODEL, tss_pkg::K_END,  tss_pkg::K_END},
        '{tss_pkg::CH_E,    1'b0, BY_MODEL, tss_pkg::K_END,  tss_pkg::K_END},
        '{tss_pkg::CH_BSL,  1'b0, BY_MODEL, tss_pkg::K_END,  tss_pkg::K_END},
        '{tss_pkg::CH_S,    1'b0, BY_MODEL, tss_pkg::K_END,  tss_pkg::K_END},
        '{tss_pkg::CH_EQ,   1'b0, BY_MODEL, tss_pkg::K_END,  tss_pkg::K_END},
        '{tss_pkg::CH_BSL,  1'b0, BY_MODEL, tss_pkg::K_END,  tss_pkg::K_END},
        '{tss_pkg::CH_BSL,  1'b0, BY_MODEL, tss_pkg::K_END,  tss_pkg::K_END},
        '{tss_pkg::CH_BSL,  1'b0, BY_MODEL, tss_pkg::K_END,  tss_pkg::K_END},
        '{"x",              1'b1, BY_MODEL, tss_pkg::K_END,  tss_pkg::K_END},
        '{"k",              1'b0, BY_MODEL, tss_pkg::K_END,  tss_pkg::K_END},
        '{tss_pkg::CH_BSL,  1'b0, BY_MODEL, tss_pkg::K_END,  tss_pkg::K_END},
        '{tss_pkg::CH_EQ,   1'b0, 0,        tss_pkg::K_END,  tss_pkg::K_END},
        '{"v",              1'b0, 1,        tss_pkg::K_ERR,  tss_pkg::K_END},
        '{tss_pkg::CH_SEMI, 1'b0, 0,        tss_pkg::K_END,  tss_pkg::K_END},
        '{"z",              1'b1, 1,        tss_pkg::K_END,  tss_pkg::K_END},
        '{"x",              1'b0, BY_MODEL, tss_pkg::K_END,  tss_pkg::K_END},
        '{tss_pkg::CH_EQ,   1'b0, BY_MODEL, tss_pkg::K_END,  tss_pkg::K_END},
        '{tss_pkg::CH_SEMI, 1'b0, 0,        tss_pkg::K_END,  tss_pkg::K_END},
        '{"y",              1'b0, BY_MODEL, tss_pkg::K_END,  tss_pkg::K_END},
        '{tss_pkg::CH_EQ,   1'b0, BY_MODEL, tss_pkg::K_END,  tss_pkg::K_END},
        '{tss_pkg::CH_BSL,  1'b1, BY_MODEL, tss_pkg::K_END,  tss_pkg::K_END}
    };

    tag_string_splitter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int unescape(input logic [7:0] c, output logic [7:0] a,
                                    output logic [7:0] b);
        a = tss_pkg::CH_BSL;
        b = c;
        if (c == tss_pkg::CH_E) begin
            a = tss_pkg::CH_EQ;
        end else if (c == tss_pkg::CH_S) begin
            a = tss_pkg::CH_SEMI;
        end
        return (c == tss_pkg::CH_E || c == tss_pkg::CH_S || c == tss_pkg::CH_BSL) ? 1 : 2;
    endfunction

    function automatic void emit(input logic [2:0] kind, input logic [7:0] b);
        t_split_result r;
        r.kind = kind;
        r.data = b;
        r.last = 1'b0;
        byte_results.insert(byte_results.size(), r);
    endfunction

    task automatic clear_segment();
        seg_phase   = SEG_KEY;
        esc_pend    = 1'b0;
        key_len     = 0;
        key_ovf     = 1'b0;
        key_esc_err = 1'b0;
    endtask

    task automatic key_put(input logic [7:0] b);
        if (key_len < tss_pkg::KEY_MAX) begin
            key_buf[key_len] = b;
            key_len++;
        end else begin
            key_ovf = 1'b1;
        end
    endtask

    task automatic val_take(input logic [7:0] c);
        logic [7:0] a;
        logic [7:0] b;
        if (esc_pend) begin
            esc_pend = 1'b0;
            if (unescape(c, a, b) == 2) begin
                emit(tss_pkg::K_VAL, a);
                emit(tss_pkg::K_VAL, b);
            end else begin
                emit(tss_pkg::K_VAL, a);
            end
        end else if (c == tss_pkg::CH_BSL) begin
            esc_pend = 1'b1;
        end else begin
            emit(tss_pkg::K_VAL, c);
        end
    endtask

    // Returns 0 when a trailing escape turns the close into an error.
    function automatic bit close_val();
        if (esc_pend) begin
            esc_pend = 1'b0;
            emit(tss_pkg::K_ERR, 8'h00);
            seg_phase = SEG_DISCARD;
            return 1'b0;
        end
        emit(tss_pkg::K_PAIR, 8'h00);
        return 1'b1;
    endfunction

    task automatic split_byte(input logic [7:0] c, input logic eos);
        logic [7:0] a;
        logic [7:0] b;
        byte_results.delete();
        case (seg_phase)
            SEG_KEY: begin
                if (c == tss_pkg::CH_SEMI) begin
                    clear_segment();
                end else if (c == tss_pkg::CH_EQ) begin
                    key_esc_err = esc_pend;
                    esc_pend = 1'b0;
                    seg_phase = SEG_VSTART;
                end else if (esc_pend) begin
                    esc_pend = 1'b0;
                    if (unescape(c, a, b) == 2) begin
                        key_put(a);
                        key_put(b);
                    end else begin
                        key_put(a);
                    end
                end else if (c == tss_pkg::CH_BSL) begin
                    esc_pend = 1'b1;
                end else begin
                    key_put(c);
                end
            end
            SEG_VSTART: begin
                if (c == tss_pkg::CH_SEMI) begin
                    clear_segment();
                end else if (c == tss_pkg::CH_EQ) begin
                    seg_phase = SEG_SKIP;
                end else if (key_ovf || key_esc_err) begin
                    emit(tss_pkg::K_ERR, 8'h00);
                    seg_phase = SEG_DISCARD;
                end else if (key_len == 0) begin
                    seg_phase = SEG_SKIP;
                end else begin
                    for (int i = 0; i < key_len; i++) begin
                        emit(tss_pkg::K_KEY, key_buf[i]);
                    end
                    seg_phase = SEG_VALUE;
                    esc_pend = 1'b0;
                    val_take(c);
                end
            end
            SEG_VALUE: begin
                if (c == tss_pkg::CH_SEMI) begin
                    if (close_val()) begin
                        clear_segment();
                    end
                end else if (c == tss_pkg::CH_EQ) begin
                    if (close_val()) begin
                        seg_phase = SEG_SKIP;
                    end
                end else begin
                    val_take(c);
                end
            end
            SEG_SKIP: begin
                if (c == tss_pkg::CH_SEMI) begin
                    clear_segment();
                end
            end
            default: begin
            end
        endcase
        if (eos) begin
            if (seg_phase == SEG_VALUE) begin
                void'(close_val());
            end
            emit(tss_pkg::K_END, 8'h00);
            clear_segment();
        end
        if (byte_results.size() > 0) begin
            byte_results[byte_results.size() - 1].last = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result kind %0d data %02h last %0b",
                                            m_axis_tuser, m_axis_tdata, m_axis_tlast));
                end else begin
                    front = expected_results.pop_front();
                    if (m_axis_tuser !== front.kind) begin
                        flag_mismatch($sformatf("kind %0d, expected %0d",
                                                m_axis_tuser, front.kind));
                    end
                    if (m_axis_tdata !== front.data) begin
                        flag_mismatch($sformatf("data %02h, expected %02h",
                                                m_axis_tdata, front.data));
                    end
                    if (m_axis_tlast !== front.last) begin
                        flag_mismatch($sformatf("tlast %0b, expected %0b",
                                                m_axis_tlast, front.last));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                bytes_in++;
                split_byte(s_axis_tdata, s_axis_tlast);
                foreach (byte_results[i]) begin
                    if (byte_results[i].kind == tss_pkg::K_PAIR) pairs_seen++;
                    if (byte_results[i].kind == tss_pkg::K_ERR) errors_seen++;
                end
                if (s_axis_tlast) strings_seen++;
                if (byte_results.size() > longest_run) longest_run = byte_results.size();
                if (drv_n_exp == BY_MODEL) begin
                    foreach (byte_results[i]) begin
                        expected_results.insert(expected_results.size(), byte_results[i]);
                    end
                end else if (drv_n_exp == 1) begin
                    exp_item.kind = drv_k0;
                    exp_item.data = 8'h00;
                    exp_item.last = 1'b1;
                    expected_results.insert(expected_results.size(), exp_item);
                end else if (drv_n_exp == 2) begin
                    exp_item.kind = drv_k0;
                    exp_item.data = 8'h00;
                    exp_item.last = 1'b0;
                    expected_results.insert(expected_results.size(), exp_item);
                    exp_item.kind = drv_k1;
                    exp_item.last = 1'b1;
                    expected_results.insert(expected_results.size(), exp_item);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Timeout: no input transfer for %0d cycles", STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin : receiver
        int pat;
        int tick;
        pat = 0;
        tick = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!hold_done && bytes_in >= HOLD_AFTER) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            tick++;
            if (tick % 50 == 0) pat = $urandom_range(0, 4);
            case (pat)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= (tick % 3 == 0);
                3: m_axis_tready <= ($urandom_range(0, 7) != 0);
                default: m_axis_tready <= (tick % 16 >= 5);
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic l, input int n_exp,
                             input logic [2:0] k0, input logic [2:0] k1);
        int r;
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            r = $urandom_range(0, 3);
            burst_left = (r == 0) ? $urandom_range(1, 4) :
                         (r == 3) ? $urandom_range(40, 120) : $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= l;
        drv_n_exp     <= n_exp;
        drv_k0        <= k0;
        drv_k1        <= k1;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do b = 8'($urandom);
        while (b == tss_pkg::CH_SEMI || b == tss_pkg::CH_EQ || b == tss_pkg::CH_BSL);
        return b;
    endfunction

    task automatic add_byte(input logic [7:0] b);
        t_tag_byte t;
        t.data = b;
        t.last = 1'b0;
        tag_bytes.insert(tag_bytes.size(), t);
    endtask

    task automatic add_text(input int len);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) < 2) begin
                add_byte(tss_pkg::CH_BSL);
                case ($urandom_range(0, 3))
                    0: add_byte(tss_pkg::CH_E);
                    1: add_byte(tss_pkg::CH_S);
                    2: add_byte(tss_pkg::CH_BSL);
                    default: add_byte(text_byte());
                endcase
            end else begin
                add_byte(text_byte());
            end
        end
    endtask

    task automatic add_segment();
        int r;
        r = $urandom_range(0, 99);
        add_text(r < 5 ? 0 : r < 15 ? $urandom_range(30, 36) : $urandom_range(1, 6));
        if ($urandom_range(0, 24) == 0) add_byte(tss_pkg::CH_BSL);
        add_byte(tss_pkg::CH_EQ);
        add_text($urandom_range(0, 11) == 0 ? 0 : $urandom_range(1, 6));
        if ($urandom_range(0, 24) == 0) add_byte(tss_pkg::CH_BSL);
        if ($urandom_range(0, 9) == 0) begin
            add_byte(tss_pkg::CH_EQ);
            add_text($urandom_range(0, 3));
        end
    endtask

    task automatic add_tag_string();
        int nseg;
        nseg = $urandom_range(1, 4);
        for (int s = 0; s < nseg; s++) begin
            if (s > 0) add_byte(tss_pkg::CH_SEMI);
            add_segment();
        end
        if ($urandom_range(0, 4) == 0) add_byte(tss_pkg::CH_SEMI);
        tag_bytes[tag_bytes.size() - 1].last = 1'b1;
    endtask

    task automatic add_noise_string();
        int len;
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 5))
                0: add_byte(tss_pkg::CH_SEMI);
                1: add_byte(tss_pkg::CH_EQ);
                2: add_byte(tss_pkg::CH_BSL);
                3: add_byte(tss_pkg::CH_E);
                4: add_byte(tss_pkg::CH_S);
                default: add_byte(8'($urandom));
            endcase
        end
        tag_bytes[tag_bytes.size() - 1].last = 1'b1;
    endtask

    initial begin
        clear_segment();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].n_exp,
                      dir_rows[i].k0, dir_rows[i].k1);
        end
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (expected_results.size() != 0);

        while (tag_bytes.size() < RANDOM_BYTES) begin
            if ($urandom_range(0, 6) == 0) begin
                add_noise_string();
            end else begin
                add_tag_string();
            end
        end
        foreach (tag_bytes[i]) begin
            send_byte(tag_bytes[i].data, tag_bytes[i].last, BY_MODEL,
                      tss_pkg::K_END, tss_pkg::K_END);
        end
        s_axis_tvalid <= 1'b0;

        do @(posedge i_clk); while (expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        end

        $display("Run covered %0d bytes in %0d tag strings, %0d pairs and %0d errors.",
                 bytes_in, strings_seen, pairs_seen, errors_seen);
        $display("Checked %0d results, at most %0d from one byte, %0d mismatches.",
                 results_seen, longest_run, errors);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/tss_pkg.sv
sv/tss_ram.sv
sv/tss_ctrl.sv
sv/tss_dp.sv
sv/tag_string_splitter.sv
sv/tss_checker.sv
dv/tb_top.sv
